[rtl/ico_pkg.sv]
// Shared types and constants for the icosphere triangle subdivider.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ico_pkg;

	localparam int FRAC_BITS   = 14;
	localparam int COORD_W     = 16;
	localparam int SUM_W       = COORD_W + 1;
	localparam int SQ_W        = 2 * SUM_W - 1;
	localparam int N_W         = SQ_W + 1;
	localparam int SEARCH_BITS = 17;
	localparam int VTX_PER_TRI = 12;
	localparam int CNT_W       = $clog2(VTX_PER_TRI);

	// Width that holds every partial product of the search and the scaled target.
	localparam int PROD_W = 2 * SEARCH_BITS + 2 + N_W;
	localparam int TGT_W  = SQ_W + 2 + 2 * FRAC_BITS;
	localparam int ACC_W  = ((PROD_W > TGT_W) ? PROD_W : TGT_W) + 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic [SQ_W-1:0]           sq_t;
	typedef logic [N_W-1:0]            norm_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec_t;

	typedef struct packed {
		vec_t a;
		vec_t b;
		vec_t c;
	} tri_t;

	typedef struct packed {
		sum_t x;
		sum_t y;
		sum_t z;
	} svec_t;

	typedef struct packed {
		sq_t x;
		sq_t y;
		sq_t z;
	} sqvec_t;

	typedef struct packed {
		svec_t  s;
		sqvec_t sq;
		norm_t  n;
	} edge_t;

endpackage

`default_nettype wire

[rtl/ico_tri_if.sv]
// Input channel: one beat carries a whole triangle of three corners.
// Depends on ico_pkg for the coordinate type.
`timescale 1ns / 1ps
`default_nettype none

interface ico_tri_if;
	logic valid;
	logic ready;
	ico_pkg::coord_t a_x, a_y, a_z;
	ico_pkg::coord_t b_x, b_y, b_z;
	ico_pkg::coord_t c_x, c_y, c_z;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready);
endinterface

`default_nettype wire

[rtl/ico_vtx_if.sv]
// Output channel: one beat carries one emitted vertex and its last flag.
// Depends on ico_pkg for the coordinate type.
`timescale 1ns / 1ps
`default_nettype none

interface ico_vtx_if;
	logic valid;
	logic ready;
	ico_pkg::coord_t out_x, out_y, out_z;
	logic last_vertex;

	modport source (output valid, out_x, out_y, out_z, last_vertex, input ready);
	modport sink (input valid, out_x, out_y, out_z, last_vertex, output ready);
endinterface

`default_nettype wire

[rtl/icosphere_triangle_subdivide.sv]
// Top level of the icosphere subdivider: front stages, three projection lanes
// and the vertex sequencer. Depends on ico_pkg, ico_tri_if, ico_vtx_if.
//
//   channel    dir   beat contents
//   corners    in    a_x..c_z, one triangle
//   vertices   out   out_x, out_y, out_z, last_vertex
//
// The first vertex is offered once its accepted triangle has passed 22 register
// stages: the accepting edge loads the first of them (three front stages, one
// set-up stage and 17 search stages in each lane, then the output hold register).
// A triangle yields 12 vertex beats, so the sustained rate is set by the single
// output port; the next triangle is accepted only while the hold register is
// empty or as the previous triangle's last vertex leaves.
// Reset clears the valid bits and the sequencer only. A stall on the output
// holds the whole pipeline in place, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module icosphere_triangle_subdivide (
	input  wire logic clk,
	input  wire logic arst_n,
	ico_tri_if.sink   corners,
	ico_vtx_if.source vertices
);

	localparam int SB = ico_pkg::SEARCH_BITS;

	logic                   en;
	ico_pkg::tri_t          tri_in;
	logic                   front_valid;
	ico_pkg::tri_t          front_corners;
	ico_pkg::edge_t [2:0]   front_edges;
	ico_pkg::vec_t [2:0]    mids;

	assign tri_in.a.x = corners.a_x;
	assign tri_in.a.y = corners.a_y;
	assign tri_in.a.z = corners.a_z;
	assign tri_in.b.x = corners.b_x;
	assign tri_in.b.y = corners.b_y;
	assign tri_in.b.z = corners.b_z;
	assign tri_in.c.x = corners.c_x;
	assign tri_in.c.y = corners.c_y;
	assign tri_in.c.z = corners.c_z;
	assign corners.ready = en;

	ico_edge_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (corners.valid),
		.corners_in  (tri_in),
		.out_valid   (front_valid),
		.corners_out (front_corners),
		.edges_out   (front_edges)
	);

	for (genvar e = 0; e < 3; e++) begin : g_lane
		ico_norm_lane u_lane (
			.clk     (clk),
			.en      (en),
			.edge_in (front_edges[e]),
			.res     (mids[e])
		);
	end

	// Corners and valid bits ride alongside the lanes, one register per lane stage.
	logic          vld_s4     [0:SB];
	ico_pkg::tri_t corners_s4 [0:SB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= SB; i++) begin
				vld_s4[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s4[0] <= front_valid;
			for (int i = 1; i <= SB; i++) begin
				vld_s4[i] <= vld_s4[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			corners_s4[0] <= front_corners;
			for (int i = 1; i <= SB; i++) begin
				corners_s4[i] <= corners_s4[i-1];
			end
		end
	end

	ico_vertex_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s4[SB]),
		.corners  (corners_s4[SB]),
		.mids     (mids),
		.en       (en),
		.vertices (vertices)
	);

endmodule

`default_nettype wire

[rtl/ico_edge_front.sv]
// Front stages s1..s3: edge sums, component squares and squared lengths.
// Depends on ico_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ico_edge_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire ico_pkg::tri_t      corners_in,
	output logic                    out_valid,
	output ico_pkg::tri_t           corners_out,
	output ico_pkg::edge_t [2:0]    edges_out
);

	function automatic ico_pkg::sum_t add_c(ico_pkg::coord_t p, ico_pkg::coord_t q);
		return ico_pkg::sum_t'(p) + ico_pkg::sum_t'(q);
	endfunction

	function automatic ico_pkg::svec_t add_v(ico_pkg::vec_t p, ico_pkg::vec_t q);
		ico_pkg::svec_t r;
		r.x = add_c(p.x, q.x);
		r.y = add_c(p.y, q.y);
		r.z = add_c(p.z, q.z);
		return r;
	endfunction

	function automatic ico_pkg::sq_t square(ico_pkg::sum_t v);
		logic signed [2*ico_pkg::SUM_W-1:0] prod;
		prod = v * v;
		return prod[ico_pkg::SQ_W-1:0];
	endfunction

	logic                  vld_s1, vld_s2, vld_s3;
	ico_pkg::tri_t         corners_s1, corners_s2, corners_s3;
	ico_pkg::svec_t [2:0]  sum_s1, sum_s2, sum_s3;
	ico_pkg::sqvec_t [2:0] sq_s2, sq_s3;
	ico_pkg::norm_t [2:0]  n_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			corners_s1 <= corners_in;
			sum_s1[0]  <= add_v(corners_in.a, corners_in.b);
			sum_s1[1]  <= add_v(corners_in.b, corners_in.c);
			sum_s1[2]  <= add_v(corners_in.c, corners_in.a);

			corners_s2 <= corners_s1;
			sum_s2     <= sum_s1;
			for (int e = 0; e < 3; e++) begin
				sq_s2[e].x <= square(sum_s1[e].x);
				sq_s2[e].y <= square(sum_s1[e].y);
				sq_s2[e].z <= square(sum_s1[e].z);
			end

			corners_s3 <= corners_s2;
			sum_s3     <= sum_s2;
			sq_s3      <= sq_s2;
			for (int e = 0; e < 3; e++) begin
				n_s3[e] <= ico_pkg::norm_t'(sq_s2[e].x) + ico_pkg::norm_t'(sq_s2[e].y)
					+ ico_pkg::norm_t'(sq_s2[e].z);
			end
		end
	end

	assign out_valid   = vld_s3;
	assign corners_out = corners_s3;
	always_comb begin
		for (int e = 0; e < 3; e++) begin
			edges_out[e].s  = sum_s3[e];
			edges_out[e].sq = sq_s3[e];
			edges_out[e].n  = n_s3[e];
		end
	end

endmodule

`default_nettype wire

[rtl/ico_norm_lane.sv]
// Projection of one edge sum onto the unit sphere: one result bit per stage.
// Each stage tests (2k-1)^2*n <= 4c^2*2^(2F) with the product kept by adds.
// Depends on ico_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ico_norm_lane (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire ico_pkg::edge_t edge_in,
	output ico_pkg::vec_t       res
);

	localparam int SB = ico_pkg::SEARCH_BITS;

	typedef logic signed [ico_pkg::ACC_W-1:0] acc_t;

	typedef struct packed {
		acc_t          p;
		acc_t          q;
		acc_t          r;
		logic [SB-1:0] k;
		logic          neg;
		logic          zero;
	} comp_t;

	// Index 0 is the set-up register (s4); index i holds the state after step i.
	comp_t st_s4 [0:SB][0:2];
	acc_t  n_s4  [0:SB];

	ico_pkg::sum_t c_in [0:2];
	ico_pkg::sq_t  sq_in [0:2];
	assign c_in[0]  = edge_in.s.x;
	assign c_in[1]  = edge_in.s.y;
	assign c_in[2]  = edge_in.s.z;
	assign sq_in[0] = edge_in.sq.x;
	assign sq_in[1] = edge_in.sq.y;
	assign sq_in[2] = edge_in.sq.z;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s4[0] <= acc_t'(edge_in.n);
			for (int j = 0; j < 3; j++) begin
				st_s4[0][j].p    <= acc_t'(edge_in.n);
				st_s4[0][j].q    <= -acc_t'(edge_in.n);
				st_s4[0][j].r    <= acc_t'(sq_in[j]) << (2 + 2 * ico_pkg::FRAC_BITS);
				st_s4[0][j].k    <= '0;
				st_s4[0][j].neg  <= c_in[j] < 0;
				st_s4[0][j].zero <= c_in[j] == '0;
			end
		end
	end

	for (genvar gi = 1; gi <= SB; gi++) begin : g_step
		localparam int B = SB - gi;

		always_ff @(posedge clk) begin
			if (en) begin
				n_s4[gi] <= n_s4[gi-1];
			end
		end

		for (genvar gj = 0; gj < 3; gj++) begin : g_comp
			acc_t  cand;
			comp_t nxt;

			always_comb begin
				nxt  = st_s4[gi-1][gj];
				cand = st_s4[gi-1][gj].p + (st_s4[gi-1][gj].q << (2 + B))
					+ (n_s4[gi-1] << (2 + 2 * B));
				if (cand <= st_s4[gi-1][gj].r) begin
					nxt.p    = cand;
					nxt.q    = st_s4[gi-1][gj].q + (n_s4[gi-1] << (1 + B));
					nxt.k[B] = 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					st_s4[gi][gj] <= nxt;
				end
			end
		end
	end

	localparam logic [SB-1:0] POS_MAX = SB'(32767);
	localparam logic [SB-1:0] NEG_MAX = SB'(32768);

	ico_pkg::coord_t out_c [0:2];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			logic [SB-1:0]   k;
			logic signed [SB:0] kn;
			k  = st_s4[SB][j].k;
			kn = -$signed({1'b0, k});
			if (st_s4[SB][j].zero) begin
				out_c[j] = '0;
			end else if (!st_s4[SB][j].neg) begin
				out_c[j] = (k > POS_MAX) ? ico_pkg::coord_t'(32767)
					: ico_pkg::coord_t'(k[ico_pkg::COORD_W-1:0]);
			end else begin
				out_c[j] = (k > NEG_MAX) ? ico_pkg::coord_t'(-32768)
					: ico_pkg::coord_t'(kn[ico_pkg::COORD_W-1:0]);
			end
		end
	end

	assign res.x = out_c[0];
	assign res.y = out_c[1];
	assign res.z = out_c[2];

endmodule

`default_nettype wire

[rtl/ico_vertex_seq.sv]
// Output sequencer: holds one finished triangle and issues its twelve vertices.
// Drives the pipeline advance. Depends on ico_pkg and ico_vtx_if.
`timescale 1ns / 1ps
`default_nettype none

module ico_vertex_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire ico_pkg::tri_t    corners,
	input  wire ico_pkg::vec_t [2:0] mids,
	output logic                  en,
	ico_vtx_if.source             vertices
);

	localparam logic [ico_pkg::CNT_W-1:0] LAST_IDX =
		ico_pkg::CNT_W'(ico_pkg::VTX_PER_TRI - 1);

	logic                       busy_q;
	logic [ico_pkg::CNT_W-1:0]  cnt_q;
	ico_pkg::tri_t              corners_q;
	ico_pkg::vec_t [2:0]        mids_q;
	ico_pkg::vec_t              sel;

	// The pipeline moves when the hold register is empty or its final beat leaves.
	assign en = !busy_q || (vertices.ready && cnt_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (en) begin
			busy_q <= in_valid;
			cnt_q  <= '0;
		end else if (vertices.ready) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			corners_q <= corners;
			mids_q    <= mids;
		end
	end

	// mids: 0 is m12, 1 is m23, 2 is m31.
	always_comb begin
		unique case (cnt_q)
			4'd0:    sel = corners_q.a;
			4'd1:    sel = mids_q[0];
			4'd2:    sel = mids_q[2];
			4'd3:    sel = corners_q.b;
			4'd4:    sel = mids_q[1];
			4'd5:    sel = mids_q[0];
			4'd6:    sel = corners_q.c;
			4'd7:    sel = mids_q[2];
			4'd8:    sel = mids_q[1];
			4'd9:    sel = mids_q[0];
			4'd10:   sel = mids_q[1];
			4'd11:   sel = mids_q[2];
			default: sel = '0;
		endcase
	end

	assign vertices.valid       = busy_q;
	assign vertices.out_x       = sel.x;
	assign vertices.out_y       = sel.y;
	assign vertices.out_z       = sel.z;
	assign vertices.last_vertex = cnt_q == LAST_IDX;

endmodule

`default_nettype wire

[tb/tb_icosphere_triangle_subdivide.sv]
// Self-checking testbench for icosphere_triangle_subdivide: drives triangles,
// predicts the twelve vertices of each and checks every output beat.
// Depends on ico_pkg, ico_tri_if, ico_vtx_if and the top-level RTL.
`timescale 1ns / 1ps

module tb_icosphere_triangle_subdivide;

	typedef struct {
		ico_pkg::coord_t x;
		ico_pkg::coord_t y;
		ico_pkg::coord_t z;
		logic            last;
	} vertex_t;

	logic clk;
	logic arst_n;
	int   errors;
	int   hold_cycles;

	vertex_t expected_vertices[$];

	ico_tri_if corners_if();
	ico_vtx_if vertices_if();

	icosphere_triangle_subdivide u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.corners  (corners_if),
		.vertices (vertices_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// Exact projection of one sum component: largest k with
	// (2k-1)^2 * n <= 4*c^2 * 2^(2F), then sign and saturation.
	function automatic ico_pkg::coord_t project_component(input ico_pkg::sum_t c,
		input logic [35:0] n);
		logic [16:0]  mag;
		logic [127:0] target;
		logic [127:0] lhs;
		logic [127:0] odd;
		logic [16:0]  k;
		logic [16:0]  t;
		int signed    r;
		if (n == 0 || c == 0)
			return '0;
		mag = (c < 0) ? 17'(-c) : 17'(c);
		target = (128'(mag) * 128'(mag) * 128'd4) << (2 * ico_pkg::FRAC_BITS);
		k = '0;
		for (int b = ico_pkg::SEARCH_BITS - 1; b >= 0; b--) begin
			t = k | (17'd1 << b);
			odd = 128'(t) * 128'd2 - 128'd1;
			lhs = odd * odd * 128'(n);
			if (lhs <= target)
				k = t;
		end
		r = (c < 0) ? -int'(k) : int'(k);
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return ico_pkg::coord_t'(r);
	endfunction

	function automatic vertex_t edge_vertex(input vertex_t p, input vertex_t q);
		ico_pkg::sum_t sx, sy, sz;
		logic [35:0]   n;
		vertex_t       v;
		sx = ico_pkg::sum_t'(p.x) + ico_pkg::sum_t'(q.x);
		sy = ico_pkg::sum_t'(p.y) + ico_pkg::sum_t'(q.y);
		sz = ico_pkg::sum_t'(p.z) + ico_pkg::sum_t'(q.z);
		n = 36'(sx * sx) + 36'(sy * sy) + 36'(sz * sz);
		v.x = project_component(sx, n);
		v.y = project_component(sy, n);
		v.z = project_component(sz, n);
		v.last = 1'b0;
		return v;
	endfunction

	task automatic queue_subdivision(input vertex_t p1, input vertex_t p2, input vertex_t p3);
		vertex_t m12, m23, m31;
		vertex_t order[12];
		m12 = edge_vertex(p1, p2);
		m23 = edge_vertex(p2, p3);
		m31 = edge_vertex(p3, p1);
		order = '{p1, m12, m31, p2, m23, m12, p3, m31, m23, m12, m23, m31};
		for (int i = 0; i < 12; i++) begin
			order[i].last = (i == 11);
			expected_vertices.insert(expected_vertices.size(), order[i]);
		end
	endtask

	function automatic int random_gap();
		if ($urandom_range(0, 3) == 0)
			return 0;
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
	endfunction

	task automatic idle_input(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			corners_if.valid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// Offers one triangle and returns after the beat is taken.
	task automatic send_triangle(input vertex_t p1, input vertex_t p2, input vertex_t p3);
		@(negedge clk);
		corners_if.valid <= 1'b1;
		corners_if.a_x <= p1.x; corners_if.a_y <= p1.y; corners_if.a_z <= p1.z;
		corners_if.b_x <= p2.x; corners_if.b_y <= p2.y; corners_if.b_z <= p2.z;
		corners_if.c_x <= p3.x; corners_if.c_y <= p3.y; corners_if.c_z <= p3.z;
		do @(posedge clk); while (!corners_if.ready);
		queue_subdivision(p1, p2, p3);
	endtask

	function automatic vertex_t make_vertex(input int x, input int y, input int z);
		vertex_t v;
		v.x = ico_pkg::coord_t'(x);
		v.y = ico_pkg::coord_t'(y);
		v.z = ico_pkg::coord_t'(z);
		v.last = 1'b0;
		return v;
	endfunction

	function automatic vertex_t raw_vertex();
		return make_vertex($urandom, $urandom, $urandom);
	endfunction

	// A point near the unit sphere, with an occasional small jitter.
	function automatic vertex_t sphere_vertex();
		real x, y, z, len;
		int  jit;
		do begin
			x = real'($urandom_range(0, 20000)) - 10000.0;
			y = real'($urandom_range(0, 20000)) - 10000.0;
			z = real'($urandom_range(0, 20000)) - 10000.0;
			len = $sqrt(x * x + y * y + z * z);
		end while (len < 1.0);
		jit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) - 3 : 0;
		return make_vertex($rtoi(x / len * 16384.0) + jit, $rtoi(y / len * 16384.0) + jit,
			$rtoi(z / len * 16384.0) - jit);
	endfunction

	task automatic test_extremes();
		int vals[6] = '{-32768, 32767, 0, 16384, -16384, 1};
		send_triangle(make_vertex(-32768, -32768, -32768), make_vertex(-32768, -32768, -32768),
			make_vertex(32767, 32767, 32767));
		send_triangle(make_vertex(32767, 32767, 32767), make_vertex(32767, 32767, 32767),
			make_vertex(-32768, 0, 32767));
		for (int i = 0; i < 6; i++)
			send_triangle(make_vertex(vals[i], 0, 0), make_vertex(0, vals[(i + 1) % 6], 0),
				make_vertex(0, 0, vals[(i + 2) % 6]));
		send_triangle(make_vertex(16384, 0, 0), make_vertex(0, 16384, 0), make_vertex(0, 0, 16384));
		send_triangle(make_vertex(1, 0, 0), make_vertex(0, 0, 1), make_vertex(0, 1, 0));
	endtask

	// Opposite corners cancel, so some edge sums are zero or nearly zero.
	task automatic test_zero_sums();
		send_triangle(make_vertex(0, 0, 0), make_vertex(0, 0, 0), make_vertex(0, 0, 0));
		send_triangle(make_vertex(16384, -5, 77), make_vertex(-16384, 5, -77),
			make_vertex(16384, -5, 77));
		send_triangle(make_vertex(-32768, 32767, 1), make_vertex(32767, -32767, -1),
			make_vertex(1, 0, 0));
		send_triangle(make_vertex(300, 400, 0), make_vertex(-300, -400, 0),
			make_vertex(300, 400, 0));
	endtask

	task automatic test_sphere_triangles(input int count);
		for (int i = 0; i < count; i++) begin
			send_triangle(sphere_vertex(), sphere_vertex(), sphere_vertex());
			idle_input(random_gap());
		end
	endtask

	task automatic test_random_triangles(input int count);
		for (int i = 0; i < count; i++) begin
			send_triangle(raw_vertex(), raw_vertex(), raw_vertex());
			idle_input(random_gap());
		end
	endtask

	// The sink holds off while the source keeps offering beats.
	task automatic test_backpressure();
		hold_cycles = 300;
		for (int i = 0; i < 12; i++)
			send_triangle(sphere_vertex(), sphere_vertex(), sphere_vertex());
		idle_input(1);
	endtask

	initial begin
		vertices_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				vertices_if.ready <= 1'b0;
				hold_cycles--;
			end else if ($urandom_range(0, 2) == 0) begin
				vertices_if.ready <= 1'b1;
			end else begin
				vertices_if.ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
				if (!vertices_if.ready && $urandom_range(0, 9) == 0)
					hold_cycles = $urandom_range(5, 30);
			end
		end
	end

	always @(posedge clk) begin
		vertex_t exp_v;
		if (arst_n && vertices_if.valid && vertices_if.ready) begin
			if (expected_vertices.size() == 0) begin
				$error("vertex beat with no expectation: %0d %0d %0d", vertices_if.out_x,
					vertices_if.out_y, vertices_if.out_z);
				errors++;
			end else begin
				exp_v = expected_vertices.pop_front();
				if (vertices_if.out_x !== exp_v.x) begin
					$error("out_x expected %0d got %0d", exp_v.x, vertices_if.out_x);
					errors++;
				end
				if (vertices_if.out_y !== exp_v.y) begin
					$error("out_y expected %0d got %0d", exp_v.y, vertices_if.out_y);
					errors++;
				end
				if (vertices_if.out_z !== exp_v.z) begin
					$error("out_z expected %0d got %0d", exp_v.z, vertices_if.out_z);
					errors++;
				end
				if (vertices_if.last_vertex !== exp_v.last) begin
					$error("last_vertex expected %0b got %0b", exp_v.last, vertices_if.last_vertex);
					errors++;
				end
			end
		end
	end

	initial begin
		int waited;
		errors = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		corners_if.valid = 1'b0;
		{corners_if.a_x, corners_if.a_y, corners_if.a_z} = '0;
		{corners_if.b_x, corners_if.b_y, corners_if.b_z} = '0;
		{corners_if.c_x, corners_if.c_y, corners_if.c_z} = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_zero_sums();
		test_sphere_triangles(150);
		test_backpressure();
		test_sphere_triangles(40);
		test_random_triangles(70);
		idle_input(1);

		waited = 0;
		while (expected_vertices.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_vertices.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[files.f]
rtl/ico_pkg.sv
rtl/ico_tri_if.sv
rtl/ico_vtx_if.sv
rtl/ico_edge_front.sv
rtl/ico_norm_lane.sv
rtl/ico_vertex_seq.sv
rtl/icosphere_triangle_subdivide.sv
tb/tb_icosphere_triangle_subdivide.sv
